[hw/rtl/pfl_pkg.sv]
// Shared types, codes and the priority table for the fault latch.
package pfl_pkg;

	localparam int unsigned CODE_W = 4;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned PRIO_W = 4;

	localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd1000;

	typedef enum logic [1:0] {
		CMD_FAULT    = 2'd0,
		CMD_CLEAR    = 2'd1,
		CMD_IGNITION = 2'd2,
		CMD_LOG_READ = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KILL_NONE = 2'd0,
		KILL_SOFT = 2'd1,
		KILL_HARD = 2'd2
	} kill_t;

	typedef enum logic [1:0] {
		MODE_NONE     = 2'd0,
		MODE_DEGRADED = 2'd1,
		MODE_FAULT    = 2'd2
	} mode_t;

	localparam logic [CODE_W-1:0] FAULT_NONE    = 4'd0;
	localparam logic [CODE_W-1:0] FAULT_LOWVOLT = 4'd1;
	localparam logic [CODE_W-1:0] FAULT_SENSOR  = 4'd6;

	localparam logic [PRIO_W-1:0] PRIO_DEFAULT = 4'd10;

	// Write request into the fault log.
	typedef struct packed {
		logic              en;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] stamp;
	} log_wr_t;

	// Read result from the fault log.
	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] stamp;
	} log_rd_t;

	// A lower number is a more urgent fault.
	function automatic logic [PRIO_W-1:0] fault_prio(input logic [CODE_W-1:0] code);
		logic [PRIO_W-1:0] p;
		case (code) inside
			4'd1:         p = 4'd1;
			4'd2:         p = 4'd2;
			[4'd3:4'd5]:  p = 4'd3;
			[4'd6:4'd7]:  p = 4'd4;
			4'd8:         p = 4'd5;
			default:      p = PRIO_DEFAULT;
		endcase
		return p;
	endfunction

endpackage

[hw/rtl/pfl_log.sv]
// Ring log of accepted faults with fill count and raw-index read.
module pfl_log #(
	parameter int unsigned LOG_DEPTH = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfl_pkg::log_wr_t  wr,
	input  logic              rd_en,
	input  logic [4:0]        rd_index,
	output pfl_pkg::log_rd_t  rd,
	output logic [4:0]        count_next
);
	import pfl_pkg::*;

	localparam int unsigned SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(LOG_DEPTH + 1);

	logic [CODE_W-1:0] codes_q [LOG_DEPTH];
	logic [TIME_W-1:0] stamps_q [LOG_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [SLOT_W-1:0] rd_slot;
	logic              rd_hit;

	always_comb begin
		count_d = count_q;
		if (wr.en && (count_q != CNT_W'(LOG_DEPTH))) begin
			count_d = count_q + 1'b1;
		end
	end

	assign count_next = 5'(count_d);

	// A read never shares an item with a write, so it sees the stored contents.
	assign rd_slot = rd_index[SLOT_W-1:0];
	assign rd_hit  = rd_en && (rd_index < 5'(count_q));

	always_comb begin
		rd = '0;
		if (rd_hit) begin
			rd.valid = 1'b1;
			rd.code  = codes_q[rd_slot];
			rd.stamp = stamps_q[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
		end else if (wr.en) begin
			count_q <= count_d;
			if (slot_q == SLOT_W'(LOG_DEPTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			codes_q[slot_q]  <= wr.code;
			stamps_q[slot_q] <= wr.stamp;
		end
	end

endmodule

[hw/rtl/priority_fault_latch_with_log.sv]
// Top level of the priority fault latch with cooldown and ring log.
//
//   Channel   Direction  Handshake             Payload
//   -------   ---------  --------------------  -----------------------------------------
//   item in   input      in_valid / in_stall   cmd, now_ms, fault_code, throttle_neutral,
//                                              steer_neutral, ignition, log_index
//   result    output     out_valid / out_stall accepted, latched, active_fault,
//                                              kill_level, emergency, mode_request,
//                                              log_valid, log_code, log_time, log_count
//   config    input      cfg_wr_en             cfg_wr_data (cooldown in milliseconds)
//
// One item is taken every cycle while in_stall is low. An item is first held in the input
// register, where the cooldown subtract-and-compare, the priority lookup and the log access
// are done, and then sits in the result register.
// Reset clears the latch, the cooldown timer base, the log write slot and the fill count;
// the log contents are not cleared, and only filled slots are ever read back.
// When out_stall is high and a result is waiting, the input register holds its item and
// in_stall rises only if that register is occupied, so one more transfer still fits.
module priority_fault_latch_with_log #(
	parameter int unsigned LOG_DEPTH = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// Input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] now_ms,
	input  logic [3:0]  fault_code,
	input  logic        throttle_neutral,
	input  logic        steer_neutral,
	input  logic        ignition,
	input  logic [4:0]  log_index,
	// Results
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic        latched,
	output logic [3:0]  active_fault,
	output logic [1:0]  kill_level,
	output logic        emergency,
	output logic [1:0]  mode_request,
	output logic        log_valid,
	output logic [3:0]  log_code,
	output logic [31:0] log_time,
	output logic [4:0]  log_count
);
	import pfl_pkg::*;

	// Input register stage.
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [TIME_W-1:0] now_s1;
	logic [CODE_W-1:0] code_s1;
	logic              thr_s1;
	logic              str_s1;
	logic              ign_s1;
	logic [4:0]        index_s1;

	// Architectural state.
	logic [TIME_W-1:0] cooldown_q;
	logic              latched_q;
	logic [CODE_W-1:0] fault_q;
	logic [TIME_W-1:0] last_time_q;
	kill_t             kill_q;
	logic              emerg_q;
	logic              ign_prev_q;

	// Next-state and result logic.
	logic              advance;
	logic              fire;
	logic              take_fault;
	logic              do_clear;
	logic [TIME_W-1:0] elapsed;
	logic              latched_d;
	logic [CODE_W-1:0] fault_d;
	kill_t             kill_d;
	logic              emerg_d;
	mode_t             mode_d;
	log_wr_t           log_wr;
	log_rd_t           log_rd;
	logic [4:0]        count_d;

	// Result register.
	logic              out_valid_q;
	logic              accepted_q;
	logic              latched_out_q;
	logic [CODE_W-1:0] fault_out_q;
	kill_t             kill_out_q;
	logic              emerg_out_q;
	mode_t             mode_out_q;
	logic              log_valid_q;
	logic [CODE_W-1:0] log_code_q;
	logic [TIME_W-1:0] log_time_q;
	logic [4:0]        log_count_q;

	// The input register moves on whenever the result register is empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= cmd_t'(cmd);
			now_s1   <= now_ms;
			code_s1  <= fault_code;
			thr_s1   <= throttle_neutral;
			str_s1   <= steer_neutral;
			ign_s1   <= ignition;
			index_s1 <= log_index;
		end
	end

	// Wrapping time since the last accepted fault; the compare is unsigned.
	assign elapsed = now_s1 - last_time_q;

	// A fault is taken when it has a code, the cooldown has run out, and it is strictly
	// more urgent than whatever is already latched.
	always_comb begin
		take_fault = (cmd_s1 == CMD_FAULT) && (code_s1 != FAULT_NONE) &&
			(elapsed >= cooldown_q) &&
			(!latched_q || (fault_prio(code_s1) < fault_prio(fault_q)));
	end

	// A clear request, or a rising edge on the ignition sample, unlatches only when a
	// fault is latched and both sticks are at neutral.
	always_comb begin
		do_clear = 1'b0;
		case (cmd_s1)
			CMD_CLEAR:    do_clear = 1'b1;
			CMD_IGNITION: do_clear = ign_s1 && !ign_prev_q;
			default:      do_clear = 1'b0;
		endcase
		do_clear = do_clear && latched_q && thr_s1 && str_s1;
	end

	always_comb begin
		latched_d = latched_q;
		fault_d   = fault_q;
		kill_d    = kill_q;
		emerg_d   = emerg_q;
		mode_d    = MODE_NONE;
		if (take_fault) begin
			latched_d = 1'b1;
			fault_d   = code_s1;
			emerg_d   = 1'b1;
			// Low voltage and sensor faults degrade; everything else goes to fault mode.
			if ((code_s1 == FAULT_SENSOR) || (code_s1 == FAULT_LOWVOLT)) begin
				kill_d = KILL_SOFT;
				mode_d = MODE_DEGRADED;
			end else begin
				kill_d = KILL_HARD;
				mode_d = MODE_FAULT;
			end
		end else if (do_clear) begin
			latched_d = 1'b0;
			fault_d   = FAULT_NONE;
			kill_d    = KILL_NONE;
			emerg_d   = 1'b0;
		end
	end

	assign log_wr.en    = fire && take_fault;
	assign log_wr.code  = code_s1;
	assign log_wr.stamp = now_s1;

	pfl_log #(
		.LOG_DEPTH(LOG_DEPTH)
	) u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (log_wr),
		.rd_en     (cmd_s1 == CMD_LOG_READ),
		.rd_index  (index_s1),
		.rd        (log_rd),
		.count_next(count_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q  <= COOLDOWN_RESET;
			latched_q   <= 1'b0;
			fault_q     <= FAULT_NONE;
			last_time_q <= '0;
			kill_q      <= KILL_NONE;
			emerg_q     <= 1'b0;
			ign_prev_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cooldown_q <= cfg_wr_data;
			end
			if (fire) begin
				latched_q <= latched_d;
				fault_q   <= fault_d;
				kill_q    <= kill_d;
				emerg_q   <= emerg_d;
				if (take_fault) begin
					last_time_q <= now_s1;
				end
				// The ignition level is only sampled by its own command.
				if (cmd_s1 == CMD_IGNITION) begin
					ign_prev_q <= ign_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q    <= take_fault;
			latched_out_q <= latched_d;
			fault_out_q   <= fault_d;
			kill_out_q    <= kill_d;
			emerg_out_q   <= emerg_d;
			mode_out_q    <= mode_d;
			log_valid_q   <= log_rd.valid;
			log_code_q    <= log_rd.code;
			log_time_q    <= log_rd.stamp;
			log_count_q   <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign latched      = latched_out_q;
	assign active_fault = fault_out_q;
	assign kill_level   = kill_out_q;
	assign emergency    = emerg_out_q;
	assign mode_request = mode_out_q;
	assign log_valid    = log_valid_q;
	assign log_code     = log_code_q;
	assign log_time     = log_time_q;
	assign log_count    = log_count_q;

endmodule

[bench/priority_fault_latch_with_log_test.sv]
// Self-checking testbench for the priority fault latch with cooldown and ring log.
`timescale 1ns / 1ps

module priority_fault_latch_with_log_test;
	import pfl_pkg::*;

	localparam int unsigned LOG_DEPTH = 5;
	// Far above the slowest legal run, which is about 1400 transfers
	// under heavy idling on both sides.
	localparam int unsigned CYCLE_LIMIT = 600000;
	// Mismatch lines stop printing after this many, but counting goes on.
	localparam int unsigned REPORT_CAP = 200;

	// One transfer into the block, field for field as on the ports.
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] now;
		logic [3:0]  code;
		logic        thr;
		logic        str;
		logic        ign;
		logic [4:0]  idx;
	} fault_item_t;

	// One result transfer out of the block.
	typedef struct packed {
		logic        accepted;
		logic        latched;
		logic [3:0]  active;
		kill_t       kill;
		logic        emerg;
		mode_t       mode;
		logic        lvalid;
		logic [3:0]  lcode;
		logic [31:0] ltime;
		logic [4:0]  lcount;
	} fault_result_t;

	// Architectural state of the latch, including the ring log.
	typedef struct {
		logic                         latched;
		logic [3:0]                   fault;
		logic [31:0]                  last_time;
		kill_t                        kill;
		logic                         emerg;
		logic [LOG_DEPTH-1:0][3:0]    codes;
		logic [LOG_DEPTH-1:0][31:0]   stamps;
		int unsigned                  wslot;
		int unsigned                  count;
		logic                         ign_prev;
	} latch_model_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = '0;
	logic [31:0] now_ms = '0;
	logic [3:0]  fault_code = '0;
	logic        throttle_neutral = 1'b0;
	logic        steer_neutral = 1'b0;
	logic        ignition = 1'b0;
	logic [4:0]  log_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic        latched;
	logic [3:0]  active_fault;
	logic [1:0]  kill_level;
	logic        emergency;
	logic [1:0]  mode_request;
	logic        log_valid;
	logic [3:0]  log_code;
	logic [31:0] log_time;
	logic [4:0]  log_count;

	priority_fault_latch_with_log #(
		.LOG_DEPTH(LOG_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.now_ms(now_ms),
		.fault_code(fault_code),
		.throttle_neutral(throttle_neutral),
		.steer_neutral(steer_neutral),
		.ignition(ignition),
		.log_index(log_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.latched(latched),
		.active_fault(active_fault),
		.kill_level(kill_level),
		.emergency(emergency),
		.mode_request(mode_request),
		.log_valid(log_valid),
		.log_code(log_code),
		.log_time(log_time),
		.log_count(log_count)
	);

	// Items waiting to be driven, and the results the latch owes us, oldest first.
	fault_item_t   pending_items[$];
	fault_result_t expected_results[$];
	fault_item_t   driven_item;

	// Two copies of the latch state: the generator runs ahead on its own copy so it
	// knows how full the log is, while the checking copy advances only on transfers
	// that the block actually accepts.
	latch_model_t gen_model;
	latch_model_t dut_model;
	logic [31:0]  cooldown_cfg;
	logic [31:0]  gen_now;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned faults_taken = 0;
	int unsigned log_hits = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lower number means more urgent. Unlisted codes share the lowest urgency.
	function automatic int unsigned urgency_rank(input logic [3:0] code);
		case (code)
			4'd1: return 1;
			4'd2: return 2;
			4'd3, 4'd4, 4'd5: return 3;
			4'd6, 4'd7: return 4;
			4'd8: return 5;
			default: return 10;
		endcase
	endfunction

	function automatic latch_model_t fresh_model();
		latch_model_t m;
		m.latched = 1'b0;
		m.fault = FAULT_NONE;
		m.last_time = '0;
		m.kill = KILL_NONE;
		m.emerg = 1'b0;
		m.codes = '0;
		m.stamps = '0;
		m.wslot = 0;
		m.count = 0;
		m.ign_prev = 1'b0;
		return m;
	endfunction

	// Advances the latch state by one item and returns the result it produces.
	function automatic fault_result_t latch_step(inout latch_model_t m, input fault_item_t it,
			input logic [31:0] cd);
		fault_result_t r;
		logic          clear_req;
		r = '0;
		// A clear request always asks to unlatch; an ignition sample asks only on a
		// rising edge against the level seen on the previous ignition sample.
		clear_req = (it.cmd == CMD_CLEAR) ||
			(it.cmd == CMD_IGNITION && !m.ign_prev && it.ign);
		// The elapsed time is a wrapping 32-bit difference, and a new fault must be
		// strictly more urgent than the one already latched.
		if (it.cmd == CMD_FAULT && it.code != FAULT_NONE && (it.now - m.last_time) >= cd &&
				(!m.latched || urgency_rank(it.code) < urgency_rank(m.fault))) begin
			r.accepted = 1'b1;
			m.fault = it.code;
			m.latched = 1'b1;
			m.last_time = it.now;
			m.codes[m.wslot] = it.code;
			m.stamps[m.wslot] = it.now;
			m.wslot = (m.wslot + 1) % LOG_DEPTH;
			if (m.count < LOG_DEPTH)
				m.count++;
			if (it.code == FAULT_SENSOR || it.code == FAULT_LOWVOLT) begin
				r.mode = MODE_DEGRADED;
				m.kill = KILL_SOFT;
			end else begin
				r.mode = MODE_FAULT;
				m.kill = KILL_HARD;
			end
			m.emerg = 1'b1;
		end
		if (clear_req && m.latched && it.thr && it.str) begin
			m.latched = 1'b0;
			m.fault = FAULT_NONE;
			m.kill = KILL_NONE;
			m.emerg = 1'b0;
		end
		if (it.cmd == CMD_IGNITION)
			m.ign_prev = it.ign;
		if (it.cmd == CMD_LOG_READ && it.idx < m.count) begin
			r.lvalid = 1'b1;
			r.lcode = m.codes[it.idx];
			r.ltime = m.stamps[it.idx];
		end
		r.latched = m.latched;
		r.active = m.fault;
		r.kill = m.kill;
		r.emerg = m.emerg;
		r.lcount = 5'(m.count);
		return r;
	endfunction

	// Queues one item and runs it through the generator's copy of the state.
	function automatic void queue_item(input cmd_t c, input logic [31:0] t,
			input logic [3:0] code, input logic thr, input logic str, input logic ign,
			input logic [4:0] idx);
		fault_item_t it;
		it = '{cmd: c, now: t, code: code, thr: thr, str: str, ign: ign, idx: idx};
		pending_items.push_back(it);
		void'(latch_step(gen_model, it, cooldown_cfg));
	endfunction

	// Random items. Time mostly creeps forward by steps comparable to the cooldown so
	// that faults get latched, cleared and relatched; some steps land right on the
	// cooldown boundary and a few jump anywhere in the 32-bit range. Log slots that
	// have never been written are never addressed: until the log is full the index
	// is either a filled slot or an index at or past the log depth.
	task automatic queue_random_items(input int unsigned n);
		int unsigned pick;
		cmd_t        c;
		logic [4:0]  idx;
		for (int unsigned k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 15)
				gen_now = gen_model.last_time + cooldown_cfg - 32'd1 + $urandom_range(2);
			else if (pick < 92)
				gen_now = gen_now + $urandom_range(0, 1500);
			else
				gen_now = $urandom();
			pick = $urandom_range(9);
			if (pick < 4)
				c = CMD_FAULT;
			else if (pick < 6)
				c = CMD_CLEAR;
			else if (pick < 8)
				c = CMD_IGNITION;
			else
				c = CMD_LOG_READ;
			if (gen_model.count == LOG_DEPTH)
				idx = ($urandom_range(99) < 70) ? 5'($urandom_range(0, 6)) :
					5'($urandom_range(0, 31));
			else if (gen_model.count != 0 && $urandom_range(1) == 1)
				idx = 5'($urandom_range(0, gen_model.count - 1));
			else
				idx = 5'($urandom_range(LOG_DEPTH, 31));
			queue_item(c, gen_now, 4'($urandom_range(15)), $urandom_range(9) != 0,
				$urandom_range(9) != 0, 1'($urandom_range(1)), idx);
		end
	endtask

	// Holds the test sequence until every queued item has been transferred and
	// every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	// The register is only written while nothing is in flight.
	task automatic write_cooldown(input logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cooldown_cfg = value;
		@(negedge clk);
	endtask

	// One phase of random traffic with its own cooldown and idling mix. Halfway
	// through, the sender holds off until every outstanding result has arrived.
	task automatic run_phase(input logic [31:0] cd, input int send_pct, input int stall_p,
			input int unsigned n);
		write_cooldown(cd);
		send_idle_pct = send_pct;
		stall_pct = stall_p;
		queue_random_items(n / 2);
		wait_drained();
		queue_random_items(n - n / 2);
		wait_drained();
	endtask

	// Driver: on an accepted transfer, the checking model advances and its result
	// joins the expected queue. A stalled item stays on the ports unchanged; once the
	// port is free the sender either idles or presents the next item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				fault_result_t r;
				r = latch_step(dut_model, driven_item, cooldown_cfg);
				expected_results.push_back(r);
				items_sent++;
				if (r.accepted)
					faults_taken++;
				if (r.lvalid)
					log_hits++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_item = pending_items.pop_front();
					cmd <= driven_item.cmd;
					now_ms <= driven_item.now;
					fault_code <= driven_item.code;
					throttle_neutral <= driven_item.thr;
					steer_neutral <= driven_item.str;
					ignition <= driven_item.ign;
					log_index <= driven_item.idx;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			error_count++;
			if (error_count <= REPORT_CAP)
				$display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
		end
	endtask

	// Monitor: every result transfer is compared with the oldest expectation, and the
	// receiver stalls at random for the next cycle.
	always @(posedge clk) begin : result_monitor
		fault_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_CAP)
						$display({"%0t: result with nothing expected, expected none, ",
							"got accepted=%0b latched=%0b"}, $time, accepted, latched);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					check_field("accepted", 32'(want.accepted), 32'(accepted));
					check_field("latched", 32'(want.latched), 32'(latched));
					check_field("active_fault", 32'(want.active), 32'(active_fault));
					check_field("kill_level", 32'(want.kill), 32'(kill_level));
					check_field("emergency", 32'(want.emerg), 32'(emergency));
					check_field("mode_request", 32'(want.mode), 32'(mode_request));
					check_field("log_valid", 32'(want.lvalid), 32'(log_valid));
					check_field("log_code", 32'(want.lcode), 32'(log_code));
					check_field("log_time", want.ltime, log_time);
					check_field("log_count", 32'(want.lcount), 32'(log_count));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				expected_results.size());
			$display("priority_fault_latch_with_log: mismatch");
			$finish;
		end
	end

	initial begin
		gen_model = fresh_model();
		dut_model = fresh_model();
		cooldown_cfg = COOLDOWN_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, running on the cooldown left by reset and with no idling.
		// Log reads before the log fills use only indexes at or past the log depth.
		queue_item(CMD_LOG_READ, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd31);
		queue_item(CMD_LOG_READ, 32'd0, 4'd15, 1'b1, 1'b1, 1'b1, 5'd5);
		// A request with no fault code is ignored outright.
		queue_item(CMD_FAULT, 32'd5000, FAULT_NONE, 1'b1, 1'b1, 1'b0, 5'd31);
		// Startup cooldown: the last fault time starts at zero.
		queue_item(CMD_FAULT, 32'd999, 4'd3, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_FAULT, 32'd1000, 4'd3, 1'b1, 1'b1, 1'b0, 5'd31);
		// Clears with one stick off neutral do nothing.
		queue_item(CMD_CLEAR, 32'd1100, 4'd0, 1'b0, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_CLEAR, 32'd1100, 4'd0, 1'b1, 1'b0, 1'b0, 5'd31);
		// A more urgent fault inside the cooldown is refused, then taken after it.
		queue_item(CMD_FAULT, 32'd1500, FAULT_LOWVOLT, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_FAULT, 32'd2000, FAULT_LOWVOLT, 1'b1, 1'b1, 1'b0, 5'd31);
		// Less urgent and equally urgent faults cannot replace the latched one.
		queue_item(CMD_FAULT, 32'd3000, 4'd2, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_FAULT, 32'd4000, FAULT_LOWVOLT, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_FAULT, 32'd5000, 4'd15, 1'b1, 1'b1, 1'b0, 5'd31);
		// Clear with both sticks neutral; the ignition field is ignored on a clear.
		queue_item(CMD_CLEAR, 32'd5000, 4'd0, 1'b1, 1'b1, 1'b1, 5'd31);
		// Clear with nothing latched leaves everything as it is.
		queue_item(CMD_CLEAR, 32'd5000, 4'd0, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_FAULT, 32'd5000, FAULT_SENSOR, 1'b1, 1'b1, 1'b0, 5'd31);
		// Ignition edge with a stick off neutral, a held level, then a real edge.
		queue_item(CMD_IGNITION, 32'd5000, 4'd0, 1'b0, 1'b1, 1'b1, 5'd31);
		queue_item(CMD_IGNITION, 32'd5000, 4'd0, 1'b1, 1'b1, 1'b1, 5'd31);
		queue_item(CMD_IGNITION, 32'd5000, 4'd0, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_IGNITION, 32'd5000, 4'd0, 1'b1, 1'b1, 1'b1, 5'd31);
		// Cooldown measured across the 32-bit wrap of the millisecond clock.
		queue_item(CMD_FAULT, 32'hFFFF_FF00, 4'd15, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_CLEAR, 32'hFFFF_FF00, 4'd0, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_FAULT, 32'h0000_0100, 4'd9, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_FAULT, 32'h0000_02E8, 4'd9, 1'b1, 1'b1, 1'b0, 5'd31);
		// Sixth accepted fault wraps the ring and overwrites the oldest slot.
		queue_item(CMD_FAULT, 32'h0000_0AB8, 4'd8, 1'b1, 1'b1, 1'b0, 5'd31);
		queue_item(CMD_LOG_READ, 32'h0000_0AB8, 4'd0, 1'b0, 1'b0, 1'b0, 5'd0);
		queue_item(CMD_LOG_READ, 32'h0000_0AB8, 4'd0, 1'b0, 1'b0, 1'b0, 5'd4);
		queue_item(CMD_LOG_READ, 32'h0000_0AB8, 4'd0, 1'b0, 1'b0, 1'b0, 5'd31);
		queue_item(CMD_CLEAR, 32'h0000_0AB8, 4'd0, 1'b1, 1'b1, 1'b0, 5'd31);
		gen_now = 32'h0000_0AB8;
		wait_drained();

		// Random phases: each rewrites the cooldown, including both extremes, and
		// uses its own idling mix on the two channels.
		run_phase(32'd0, 81, 0, 350);
		run_phase(32'hFFFF_FFFF, 0, 81, 250);
		run_phase(32'($urandom_range(1, 2000)), 21, 21, 400);
		run_phase(32'd1000, 0, 0, 350);

		repeat (6) @(posedge clk);
		$display("Sent %0d transfers over five cooldown settings and checked %0d results.",
			items_sent, results_checked);
		$display("Faults latched: %0d, log reads that hit a filled slot: %0d, field errors: %0d.",
			faults_taken, log_hits, error_count);
		if (error_count == 0) begin
			$display("priority_fault_latch_with_log: match");
		end else begin
			$display("priority_fault_latch_with_log: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pfl_pkg.sv
hw/rtl/pfl_log.sv
hw/rtl/priority_fault_latch_with_log.sv
bench/priority_fault_latch_with_log_test.sv
